// ===== rtl/sotd_pkg.sv =====
// Shared constants for the self-orthogonal threshold decoder.
// Holds field widths, configuration register indexes and parameter defaults.
// No dependencies.
package sotd_pkg;

    // Generator tap masks: one per data/check branch pair, bit p is power p
    localparam int TAP_W      = 7;
    localparam int NUM_TAPS   = 4;
    localparam int TAP_IDX_W  = 2;
    localparam int DIST_W     = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK_0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK_1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK_2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK_3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 3'd4;

    // Reset values of the configuration registers
    localparam logic [TAP_W-1:0]  TAP_MASK_0_RST   = 7'd101;
    localparam logic [TAP_W-1:0]  TAP_MASK_N_RST   = 7'd0;
    localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 8'd5;

    // Parameter defaults
    localparam int DATA_BITS_DEF    = 1;
    localparam int CHECK_BITS_DEF   = 1;
    localparam int MEMORY_ORDER_DEF = 6;

endpackage

// ===== rtl/self_orthogonal_threshold_decoder.sv =====
// Majority-logic (threshold) decoder for a convolutional self-orthogonal code.
// Depends on sotd_pkg for widths, register indexes and defaults.
// Single module: history, syndrome, decision and a two-entry output register.

// One code block (DATA_BITS data bits and CHECK_BITS check bits) is taken per
// word on the s_ side, and every block yields exactly one decoded word on the
// m_ side, carrying the corrected data bits of the block received MEMORY_ORDER
// words earlier (taken from an all-zero history until it fills). Throughput is
// one word per clock while s_tready is high: re-encoding, syndrome update and
// the per-branch majority decisions are all done in one pass of bit logic
// feeding the history and syndrome registers, so a new word can follow in the
// very next cycle. Each result is registered in the main output register, or
// in the skid register while the output is stalled, so a word is still taken
// while one result waits; s_tready drops only when both are full. The user
// must write tap masks and min_distance via the cfg_ port only while no word
// is in flight, unenforced by the block; writes to index 5 or above are ignored.
module self_orthogonal_threshold_decoder #(
    parameter int DATA_BITS    = sotd_pkg::DATA_BITS_DEF,
    parameter int CHECK_BITS   = sotd_pkg::CHECK_BITS_DEF,
    parameter int MEMORY_ORDER = sotd_pkg::MEMORY_ORDER_DEF,
    localparam int S_DATA_W    = ((DATA_BITS + CHECK_BITS + 7) / 8) * 8,
    localparam int M_DATA_W    = ((DATA_BITS + 7) / 8) * 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [sotd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sotd_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // received_data [DATA_BITS-1:0], received_check above it, zero padded
    input  logic [S_DATA_W-1:0]              s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // decoded_data [DATA_BITS-1:0], zero padded
    output logic [M_DATA_W-1:0]              m_tdata
);

    localparam int HIST_W = MEMORY_ORDER + 1;
    localparam int CNT_W  = $clog2(CHECK_BITS * sotd_pkg::TAP_W + 1);

    // Configuration registers
    logic [sotd_pkg::TAP_W-1:0]  tap_mask_reg [sotd_pkg::NUM_TAPS];
    logic [sotd_pkg::DIST_W-1:0] min_distance_reg;

    // Decoder state, bit 0 newest
    logic [HIST_W-1:0] data_hist_reg  [DATA_BITS];
    logic [HIST_W-1:0] data_hist_next [DATA_BITS];
    logic [HIST_W-1:0] syn_hist_reg   [CHECK_BITS];

    // Output register and skid stage
    logic                 m_valid_reg;
    logic [DATA_BITS-1:0] m_data_reg;
    logic                 skid_valid_reg;
    logic [DATA_BITS-1:0] skid_data_reg;

    logic [DATA_BITS-1:0]  rx_data;
    logic [CHECK_BITS-1:0] rx_check;
    logic [sotd_pkg::TAP_W-1:0] taps    [DATA_BITS][CHECK_BITS];
    logic [HIST_W-1:0]          rev_pos [DATA_BITS][CHECK_BITS];
    logic [HIST_W-1:0]          syn_stage [DATA_BITS+1][CHECK_BITS];
    logic [CHECK_BITS-1:0]      parity;
    logic [CNT_W-1:0]           count  [DATA_BITS];
    logic [DATA_BITS-1:0]       flip;
    logic [DATA_BITS-1:0]       decoded;
    logic                       accept;
    logic                       out_free;

    assign rx_data  = s_tdata[DATA_BITS-1:0];
    assign rx_check = s_tdata[DATA_BITS +: CHECK_BITS];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Tap lookup per pair and the reversed syndrome positions they read
    always_comb begin
        for (int d = 0; d < DATA_BITS; d++) begin
            for (int c = 0; c < CHECK_BITS; c++) begin
                if (d * CHECK_BITS + c < sotd_pkg::NUM_TAPS) begin
                    taps[d][c] = tap_mask_reg[sotd_pkg::TAP_IDX_W'(d * CHECK_BITS + c)];
                end else begin
                    taps[d][c] = '0;
                end
                rev_pos[d][c] = '0;
                for (int p = 0; p < sotd_pkg::TAP_W; p++) begin
                    if (p <= MEMORY_ORDER) begin
                        rev_pos[d][c][MEMORY_ORDER-p] = taps[d][c][p];
                    end
                end
            end
        end
    end

    // Re-encode and form the new syndrome bits
    always_comb begin
        for (int d = 0; d < DATA_BITS; d++) begin
            data_hist_next[d] = {data_hist_reg[d][HIST_W-2:0], rx_data[d]};
        end
        for (int c = 0; c < CHECK_BITS; c++) begin
            parity[c] = rx_check[c];
            for (int d = 0; d < DATA_BITS; d++) begin
                for (int p = 0; p < sotd_pkg::TAP_W; p++) begin
                    if (p <= MEMORY_ORDER) begin
                        parity[c] = parity[c] ^ (data_hist_next[d][p] & taps[d][c][p]);
                    end
                end
            end
        end
    end

    // Majority decisions, branch by branch; each flip clears the syndrome
    // bits it used before the next branch counts.
    always_comb begin
        for (int c = 0; c < CHECK_BITS; c++) begin
            syn_stage[0][c] = {syn_hist_reg[c][HIST_W-2:0], parity[c]};
        end
        for (int d = 0; d < DATA_BITS; d++) begin
            count[d] = '0;
            for (int c = 0; c < CHECK_BITS; c++) begin
                for (int q = 0; q < HIST_W; q++) begin
                    count[d] = count[d]
                        + CNT_W'(syn_stage[d][c][q] & rev_pos[d][c][q]);
                end
            end
            flip[d] = ({{sotd_pkg::DIST_W{1'b0}}, count[d], 1'b0}
                       >= {{(CNT_W + 1){1'b0}}, min_distance_reg});
            for (int c = 0; c < CHECK_BITS; c++) begin
                syn_stage[d+1][c] = flip[d] ? (syn_stage[d][c] & ~rev_pos[d][c])
                                            : syn_stage[d][c];
            end
            decoded[d] = data_hist_next[d][MEMORY_ORDER] ^ flip[d];
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_mask_reg[0]  <= sotd_pkg::TAP_MASK_0_RST;
            for (int i = 1; i < sotd_pkg::NUM_TAPS; i++) begin
                tap_mask_reg[i] <= sotd_pkg::TAP_MASK_N_RST;
            end
            min_distance_reg <= sotd_pkg::MIN_DISTANCE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sotd_pkg::CFG_TAP_MASK_0: begin
                    tap_mask_reg[0] <= cfg_wdata[sotd_pkg::TAP_W-1:0];
                end
                sotd_pkg::CFG_TAP_MASK_1: begin
                    tap_mask_reg[1] <= cfg_wdata[sotd_pkg::TAP_W-1:0];
                end
                sotd_pkg::CFG_TAP_MASK_2: begin
                    tap_mask_reg[2] <= cfg_wdata[sotd_pkg::TAP_W-1:0];
                end
                sotd_pkg::CFG_TAP_MASK_3: begin
                    tap_mask_reg[3] <= cfg_wdata[sotd_pkg::TAP_W-1:0];
                end
                sotd_pkg::CFG_MIN_DISTANCE: begin
                    min_distance_reg <= cfg_wdata[sotd_pkg::DIST_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // History and syndrome state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < DATA_BITS; d++) begin
                data_hist_reg[d] <= '0;
            end
            for (int c = 0; c < CHECK_BITS; c++) begin
                syn_hist_reg[c] <= '0;
            end
        end else if (accept) begin
            for (int d = 0; d < DATA_BITS; d++) begin
                data_hist_reg[d] <= data_hist_next[d];
            end
            for (int c = 0; c < CHECK_BITS; c++) begin
                syn_hist_reg[c] <= syn_stage[DATA_BITS][c];
            end
        end
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg    <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (accept) begin
                m_data_reg <= decoded;
            end
        end else if (accept) begin
            skid_data_reg <= decoded;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'(m_data_reg);

    // Skid stage only ever holds a word behind a waiting output word
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid word held with output register empty");

    // A word taken while the output is stalled must land in the skid stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready && accept) |=> skid_valid_reg)
        else $error("word accepted under stall was lost");

    // A word taken while the output is free shows up next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && out_free) |=> m_valid_reg)
        else $error("accepted word did not reach the output");

endmodule
